// ===== hdl/eadsr_pkg.sv =====
// Shared types and constants for the exponential ADSR envelope generator.
// Used by eadsr_cfg_regs, eadsr_core and exponential_adsr_envelope.
`timescale 1ns / 1ps

package eadsr_pkg;

    localparam int LEVEL_W    = 17;
    localparam int COEFF_W    = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'd65536;

    // bit positions in mode_flags
    localparam int MODE_ATTACK_INSTANT  = 0;
    localparam int MODE_DECAY_INSTANT   = 1;
    localparam int MODE_RELEASE_INSTANT = 2;
    localparam int MODE_CHAIN_ON        = 3;
    localparam int MODE_CHAIN_OFF       = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ATTACK_COEFF   = 3'd0,
        REG_ATTACK_OFFSET  = 3'd1,
        REG_DECAY_COEFF    = 3'd2,
        REG_DECAY_OFFSET   = 3'd3,
        REG_RELEASE_COEFF  = 3'd4,
        REG_RELEASE_OFFSET = 3'd5,
        REG_SUSTAIN_LEVEL  = 3'd6,
        REG_MODE_FLAGS     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [15:0] attack_coeff;
        logic        [16:0] attack_offset;
        logic        [15:0] decay_coeff;
        logic signed [17:0] decay_offset;
        logic        [15:0] release_coeff;
        logic signed [10:0] release_offset;
        logic        [16:0] sustain_level;
        logic        [4:0]  mode_flags;
    } cfg_t;

    typedef struct packed {
        logic               chain_off;
        logic               chain_on;
        logic [LEVEL_W-1:0] level;
    } result_t;

endpackage

// ===== hdl/eadsr_cfg_regs.sv =====
// Configuration register file of the envelope generator.
// Depends on eadsr_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module eadsr_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [eadsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [eadsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output eadsr_pkg::cfg_t                  cfg
);
    import eadsr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_coeff   <= 16'd64936;
            cfg_reg.attack_offset  <= 17'd737;
            cfg_reg.decay_coeff    <= 16'd65458;
            cfg_reg.decay_offset   <= 18'sd62;
            cfg_reg.release_coeff  <= 16'd65280;
            cfg_reg.release_offset <= -11'sd2;
            cfg_reg.sustain_level  <= 17'd52429;
            cfg_reg.mode_flags     <= 5'd0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_ATTACK_COEFF:   cfg_reg.attack_coeff   <= cfg_wdata[15:0];
                REG_ATTACK_OFFSET:  cfg_reg.attack_offset  <= cfg_wdata[16:0];
                REG_DECAY_COEFF:    cfg_reg.decay_coeff    <= cfg_wdata[15:0];
                REG_DECAY_OFFSET:   cfg_reg.decay_offset   <= $signed(cfg_wdata[17:0]);
                REG_RELEASE_COEFF:  cfg_reg.release_coeff  <= cfg_wdata[15:0];
                REG_RELEASE_OFFSET: cfg_reg.release_offset <= $signed(cfg_wdata[10:0]);
                REG_SUSTAIN_LEVEL:  cfg_reg.sustain_level  <= cfg_wdata[16:0];
                REG_MODE_FLAGS:     cfg_reg.mode_flags     <= cfg_wdata[4:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/eadsr_core.sv =====
// Envelope phase sequencer and one-pole multiply-add for one gate sample.
// Depends on eadsr_pkg for cfg_t, result_t and the fixed-point constants.
`timescale 1ns / 1ps

module eadsr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               gate,
    input  eadsr_pkg::cfg_t    cfg,
    output eadsr_pkg::result_t res
);
    import eadsr_pkg::*;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next, phase_edge;
    logic [LEVEL_W-1:0] env_level_reg, env_level_next;
    logic               gate_prev_reg;
    logic               on_edge, off_edge, off_end;

    logic [COEFF_W-1:0]       coeff_sel;
    logic signed [19:0]       offset_sel;
    logic [32:0]              prod;
    logic [32:0]              prod_rnd;
    logic signed [19:0]       curve_v;
    logic [LEVEL_W-1:0]       curve_clamped;
    logic [LEVEL_W-1:0]       sustain_eff;

    // gate edges move the phase before the level update
    always_comb
    begin
        phase_edge = phase_reg;
        on_edge    = 1'b0;
        off_edge   = 1'b0;
        if (gate && !gate_prev_reg)
        begin
            if (phase_reg != PH_ATTACK)
            begin
                phase_edge = PH_ATTACK;
                on_edge    = cfg.mode_flags[MODE_CHAIN_ON];
            end
        end
        else if (!gate && gate_prev_reg)
        begin
            if (env_level_reg != '0)
            begin
                if (phase_reg != PH_RELEASE)
                    phase_edge = PH_RELEASE;
            end
            else if (phase_reg != PH_OFF)
            begin
                phase_edge = PH_OFF;
                off_edge   = cfg.mode_flags[MODE_CHAIN_OFF];
            end
        end
    end

    always_comb
    begin
        case (phase_edge)
            PH_ATTACK:
            begin
                coeff_sel  = cfg.attack_coeff;
                offset_sel = $signed({3'b000, cfg.attack_offset});
            end
            PH_DECAY:
            begin
                coeff_sel  = cfg.decay_coeff;
                offset_sel = 20'(cfg.decay_offset);
            end
            PH_RELEASE:
            begin
                coeff_sel  = cfg.release_coeff;
                offset_sel = 20'(cfg.release_offset);
            end
            default:
            begin
                coeff_sel  = '0;
                offset_sel = '0;
            end
        endcase
    end

    // round half up at bit 16, then add the phase offset
    assign prod     = 33'(env_level_reg) * 33'(coeff_sel);
    assign prod_rnd = prod + 33'd32768;
    assign curve_v  = $signed({3'b000, prod_rnd[32:16]}) + offset_sel;

    assign curve_clamped = (curve_v < 20'sd0) ? '0 :
                           (curve_v > $signed({3'b000, FULL_SCALE})) ? FULL_SCALE :
                           curve_v[LEVEL_W-1:0];

    assign sustain_eff = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;

    always_comb
    begin
        phase_next     = phase_edge;
        env_level_next = env_level_reg;
        off_end        = 1'b0;
        case (phase_edge)
            PH_OFF:
                env_level_next = '0;
            PH_ATTACK:
            begin
                if (curve_v >= $signed({3'b000, FULL_SCALE})
                    || cfg.mode_flags[MODE_ATTACK_INSTANT])
                begin
                    env_level_next = FULL_SCALE;
                    phase_next     = PH_DECAY;
                end
                else
                    env_level_next = curve_clamped;
            end
            PH_DECAY:
            begin
                env_level_next = curve_clamped;
                if (curve_v <= $signed({3'b000, sustain_eff})
                    || cfg.mode_flags[MODE_DECAY_INSTANT])
                    phase_next = PH_SUSTAIN;
            end
            PH_SUSTAIN:
                env_level_next = sustain_eff;
            PH_RELEASE:
            begin
                if (curve_v <= 20'sd0 || cfg.mode_flags[MODE_RELEASE_INSTANT])
                begin
                    env_level_next = '0;
                    phase_next     = PH_OFF;
                    off_end        = cfg.mode_flags[MODE_CHAIN_OFF];
                end
                else
                    env_level_next = curve_clamped;
            end
            default:
                env_level_next = env_level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OFF;
            env_level_reg <= '0;
            gate_prev_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            env_level_reg <= env_level_next;
            gate_prev_reg <= gate;
        end
    end

    assign res.level     = env_level_next;
    assign res.chain_on  = on_edge;
    assign res.chain_off = off_edge | off_end;

endmodule

// ===== hdl/exponential_adsr_envelope.sv =====
// Exponential ADSR envelope generator, top level.
// Usage:
//   s_tvalid/s_tready/s_tdata carry one gate sample per audio tick; each word
//   accepted gives exactly one result word on m_tvalid/m_tready/m_tdata with
//   the envelope level (Q.16, 65536 = 1.0) and the chain on/off pulses.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata, one per clock;
//   the user must do so only while no sample is in flight; the block does not enforce it.
// Path: an accepted word is held in the input register, then passes the
//   multiply-add into the result register, whose valid flag drives m_tvalid.
// Throughput: one word per cycle while m_tready stays high; the single 17x16
//   multiply-add sits between the input register and the result register.
// Reset: phase off, level zero, gate history low, registers at their
//   defaults, both channel registers empty.
// Stall: while the result register is held by a low m_tready the input
//   register can still take one word; after that s_tready drops until the
//   result is taken. No word is lost or repeated.
// Depends on eadsr_pkg, eadsr_cfg_regs and eadsr_core.
`timescale 1ns / 1ps

module exponential_adsr_envelope (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [eadsr_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] gate, [7:1] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [eadsr_pkg::OUT_DATA_W-1:0] m_tdata,   // [16:0] level, [17] chain_on,
                                                        // [18] chain_off, [23:19] zero
    input  logic                             cfg_we,
    input  logic [eadsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [eadsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import eadsr_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    logic in_valid_reg, in_valid_next;
    logic gate_reg;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic in_take;

    eadsr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    eadsr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .gate  (gate_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // advance the held sample whenever the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            gate_reg <= s_tdata[0];
        if (advance)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, res_reg.chain_off, res_reg.chain_on, res_reg.level};

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] <= FULL_SCALE))
        else $error("envelope level above full scale");

    a_pulse_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[17] && m_tdata[18]))
        else $error("chain on and chain off raised together");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("advanced sample did not reach the result register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |=> in_valid_reg)
        else $error("held input word dropped during output stall");

endmodule

// ===== tb/envelope_checker.sv =====
// Checker for the exponential ADSR envelope: watches the gate, result and register ports,
// keeps its own envelope state and compares every result word with its prediction.
// Depends on eadsr_pkg for the register indexes and the result layout.
`timescale 1ns / 1ps

module envelope_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [eadsr_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] gate, [7:1] zero
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [eadsr_pkg::OUT_DATA_W-1:0] m_tdata,   // [16:0] level, [17] chain_on,
                                                        // [18] chain_off, [23:19] zero
    input  logic                             cfg_we,
    input  logic [eadsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [eadsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                               mismatches,
    output int                               outstanding
);
    import eadsr_pkg::*;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } env_phase_t;

    cfg_t               regs;
    env_phase_t         phase;
    logic [LEVEL_W-1:0] env;
    logic               gate_last;
    logic               on_pulse;
    logic               off_pulse;
    result_t            envelope_due[$];
    result_t            got_word;
    result_t            want_word;
    int                 words_seen;

    function automatic longint clamp_q16(input longint v);
        if (v < 0)
            return 0;
        if (v > longint'(FULL_SCALE))
            return longint'(FULL_SCALE);
        return v;
    endfunction

    function automatic longint sustain_target();
        return clamp_q16(longint'(regs.sustain_level));
    endfunction

    // one-pole step: offset + level*coeff, product rounded half up at bit 16
    function automatic longint one_pole(input longint offset, input logic [COEFF_W-1:0] coeff);
        longint prod;
        prod = longint'(env) * longint'(coeff);
        return offset + ((prod + 32768) >> 16);
    endfunction

    function automatic void move_to(input env_phase_t p);
        if (phase == p)
            return;
        phase = p;
        if (p == PH_ATTACK && regs.mode_flags[MODE_CHAIN_ON])
            on_pulse = 1'b1;
        if (p == PH_OFF && regs.mode_flags[MODE_CHAIN_OFF])
            off_pulse = 1'b1;
    endfunction

    function automatic result_t next_envelope(input logic gate);
        longint  v;
        result_t r;
        on_pulse  = 1'b0;
        off_pulse = 1'b0;
        if (gate && !gate_last)
            move_to(PH_ATTACK);
        else if (!gate && gate_last)
            move_to(env != 0 ? PH_RELEASE : PH_OFF);
        gate_last = gate;

        case (phase)
            PH_OFF:
                env = '0;
            PH_ATTACK:
            begin
                v = one_pole(longint'(regs.attack_offset), regs.attack_coeff);
                if (v >= longint'(FULL_SCALE) || regs.mode_flags[MODE_ATTACK_INSTANT])
                begin
                    env = FULL_SCALE;
                    move_to(PH_DECAY);
                end
                else
                begin
                    env = LEVEL_W'(clamp_q16(v));
                end
            end
            PH_DECAY:
            begin
                v = one_pole(longint'($signed(regs.decay_offset)), regs.decay_coeff);
                env = LEVEL_W'(clamp_q16(v));
                // the unclamped value decides the end of the decay
                if (v <= sustain_target() || regs.mode_flags[MODE_DECAY_INSTANT])
                    move_to(PH_SUSTAIN);
            end
            PH_SUSTAIN:
                env = LEVEL_W'(sustain_target());
            PH_RELEASE:
            begin
                v = one_pole(longint'($signed(regs.release_offset)), regs.release_coeff);
                if (v <= 0 || regs.mode_flags[MODE_RELEASE_INSTANT])
                begin
                    env = '0;
                    move_to(PH_OFF);
                end
                else
                begin
                    env = LEVEL_W'(clamp_q16(v));
                end
            end
            default:
                ;
        endcase

        r.level     = env;
        r.chain_on  = on_pulse;
        r.chain_off = off_pulse;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t envelope_checker: result %0d, %s: got %0d, expected %0d",
                 $time, words_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.attack_coeff   = 16'd64936;
            regs.attack_offset  = 17'd737;
            regs.decay_coeff    = 16'd65458;
            regs.decay_offset   = 18'sd62;
            regs.release_coeff  = 16'd65280;
            regs.release_offset = -11'sd2;
            regs.sustain_level  = 17'd52429;
            regs.mode_flags     = 5'd0;
            phase      = PH_OFF;
            env        = '0;
            gate_last  = 1'b0;
            on_pulse   = 1'b0;
            off_pulse  = 1'b0;
            words_seen = 0;
            mismatches = 0;
            envelope_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_word = result_t'(m_tdata[LEVEL_W+1:0]);
                if (envelope_due.size() == 0)
                begin
                    report_mismatch("word with nothing due, level", got_word.level, -1);
                end
                else
                begin
                    want_word = envelope_due.pop_front();
                    if (got_word.level !== want_word.level)
                        report_mismatch("level", got_word.level, want_word.level);
                    if (got_word.chain_on !== want_word.chain_on)
                        report_mismatch("chain_on", got_word.chain_on, want_word.chain_on);
                    if (got_word.chain_off !== want_word.chain_off)
                        report_mismatch("chain_off", got_word.chain_off, want_word.chain_off);
                end
                if (m_tdata[OUT_DATA_W-1:LEVEL_W+2] !== '0)
                    report_mismatch("padding", m_tdata[OUT_DATA_W-1:LEVEL_W+2], 0);
                words_seen++;
            end

            if (s_tvalid && s_tready)
                envelope_due.push_back(next_envelope(s_tdata[0]));

            // register writes take effect from the next gate word
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_addr))
                    REG_ATTACK_COEFF:   regs.attack_coeff   = cfg_wdata[COEFF_W-1:0];
                    REG_ATTACK_OFFSET:  regs.attack_offset  = cfg_wdata[16:0];
                    REG_DECAY_COEFF:    regs.decay_coeff    = cfg_wdata[COEFF_W-1:0];
                    REG_DECAY_OFFSET:   regs.decay_offset   = cfg_wdata[17:0];
                    REG_RELEASE_COEFF:  regs.release_coeff  = cfg_wdata[COEFF_W-1:0];
                    REG_RELEASE_OFFSET: regs.release_offset = cfg_wdata[10:0];
                    REG_SUSTAIN_LEVEL:  regs.sustain_level  = cfg_wdata[LEVEL_W-1:0];
                    REG_MODE_FLAGS:     regs.mode_flags     = cfg_wdata[4:0];
                    default:            ;
                endcase
            end

            outstanding <= envelope_due.size();
        end
    end

endmodule

// ===== tb/exponential_adsr_envelope_tb.sv =====
// Testbench top for exponential_adsr_envelope: drives gate words, result back-pressure and
// register writes; the verdict comes from envelope_checker. Depends on eadsr_pkg and the RTL.
`timescale 1ns / 1ps

module exponential_adsr_envelope_tb;
    import eadsr_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches;
    int outstanding;

    always #4 clk = ~clk;

    exponential_adsr_envelope dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    envelope_checker env_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_gate(input logic gate);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(gate);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // hold the input until every result due has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        put_reg(REG_ATTACK_COEFF,   CFG_DATA_W'(c.attack_coeff));
        put_reg(REG_ATTACK_OFFSET,  CFG_DATA_W'(c.attack_offset));
        put_reg(REG_DECAY_COEFF,    CFG_DATA_W'(c.decay_coeff));
        put_reg(REG_DECAY_OFFSET,   CFG_DATA_W'(c.decay_offset));
        put_reg(REG_RELEASE_COEFF,  CFG_DATA_W'(c.release_coeff));
        put_reg(REG_RELEASE_OFFSET, CFG_DATA_W'(c.release_offset));
        put_reg(REG_SUSTAIN_LEVEL,  CFG_DATA_W'(c.sustain_level));
        put_reg(REG_MODE_FLAGS,     CFG_DATA_W'(c.mode_flags));
        cfg_we <= 1'b0;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.attack_coeff   = 16'($urandom_range(65535));
        c.attack_offset  = 17'($urandom_range(131071));
        c.decay_coeff    = 16'($urandom_range(65535));
        c.decay_offset   = 18'(int'($urandom_range(66560)) - 1024);
        c.release_coeff  = 16'($urandom_range(65535));
        c.release_offset = 11'(int'($urandom_range(1024)) - 1024);
        c.sustain_level  = 17'($urandom_range(65536));
        c.mode_flags     = 5'($urandom_range(31));
        return c;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // bits are sent from bit 0 upwards
    task automatic send_pattern(input logic [31:0] gates, input int count);
        for (int i = 0; i < count; i++)
            send_gate(gates[i]);
    endtask

    // notes: alternating held and released runs, with some chatter and stray flips
    task automatic play_notes(input int count);
        int   sent;
        int   run;
        logic held;
        sent = 0;
        held = 1'b0;
        while (sent < count)
        begin
            held = !held;
            case ($urandom_range(9))
                0:       run = $urandom_range(1, 3);
                1:       run = $urandom_range(100, 400);
                default: run = $urandom_range(1, 48);
            endcase
            // trim the last run to the word budget
            if (run > count - sent)
                run = count - sent;
            repeat (run)
            begin
                send_gate(held ^ ($urandom_range(19) == 0));
                sent++;
            end
            if ($urandom_range(30) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        cfg_t setting;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quick curves: attack in three words, decay in five, release in four
        setting = '{attack_coeff: 16'd32768, attack_offset: 17'd40000,
                    decay_coeff: 16'd49152, decay_offset: 18'sd4096,
                    release_coeff: 16'd32768, release_offset: -11'sd1024,
                    sustain_level: 17'd30000, mode_flags: 5'b11000};
        load_settings(setting);
        send_pattern(32'h0000_83FE, 17);
        drain_results();

        // every phase instant, sustain above full scale
        setting.attack_coeff  = '0;
        setting.attack_offset = '0;
        setting.sustain_level = 17'h1FFFF;
        setting.mode_flags    = 5'b11111;
        load_settings(setting);
        send_pattern(32'h0000_0007, 4);
        drain_results();

        // attack stuck at zero, so the falling gate goes straight to off
        setting.mode_flags = 5'b11110;
        load_settings(setting);
        send_pattern(32'h0000_0001, 2);

        for (int run_no = 0; run_no < 10; run_no++)
        begin
            drain_results();
            case (run_no)
                1:
                    setting = '0;
                2:
                    setting = '{attack_coeff: 16'hFFFF, attack_offset: 17'h1FFFF,
                                decay_coeff: 16'hFFFF, decay_offset: 18'sd65536,
                                release_coeff: 16'hFFFF, release_offset: 11'sd0,
                                sustain_level: 17'd65536, mode_flags: 5'b11000};
                3:
                    setting = '{attack_coeff: 16'd64936, attack_offset: 17'd737,
                                decay_coeff: 16'd65458, decay_offset: 18'sd62,
                                release_coeff: 16'd65280, release_offset: -11'sd2,
                                sustain_level: 17'd52429, mode_flags: 5'b00000};
                default:
                    setting = random_settings();
            endcase
            load_settings(setting);
            set_idling(run_no % 4);
            play_notes(193);
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0)
            $display("exponential_adsr_envelope_tb: done, clean");
        else
            $display("exponential_adsr_envelope_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("exponential_adsr_envelope_tb: done, errors");
        $finish;
    end

endmodule
